/* sv/rate_paced_sensor_scale_ema_defines.svh */
// ----------------------------------------------------------------------------
// rate paced sensor scale ema - assertion macros
// Shared property macros for the checker, clocked on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef RATE_PACED_SENSOR_SCALE_EMA_DEFINES_SVH
`define RATE_PACED_SENSOR_SCALE_EMA_DEFINES_SVH

// same-cycle implication
`define RPSE_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rpse assertion failed");

// next-cycle implication
`define RPSE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rpse assertion failed");

`endif

/* sv/rpse_pkg.sv */
// ----------------------------------------------------------------------------
// rpse_pkg
// Types, widths and codes shared by the sensor scale / moving average block.
// ----------------------------------------------------------------------------
package rpse_pkg;

  localparam int TICKS_PER_SECOND_DEF = 1000000;
  localparam int SAMPLE_BITS_DEF      = 16;

  localparam int TICK_W   = 20;
  localparam int RATE_W   = 20;
  localparam int WEIGHT_W = 17;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 3;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 22;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [WEIGHT_W-1:0] ONE_Q16 = WEIGHT_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENSOR_MODE = 3'd0,
    CFG_RATE_SLOW   = 3'd1,
    CFG_RATE_MEDIUM = 3'd2,
    CFG_RATE_FAST   = 3'd3,
    CFG_SCALE_GAIN  = 3'd4,
    CFG_SCALE_OFFSET = 3'd5,
    CFG_EMA_WEIGHT  = 3'd6,
    CFG_UNUSED      = 3'd7
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_SLOW   = 2'd1,
    MODE_MEDIUM = 2'd2,
    MODE_FAST   = 2'd3
  } sensor_mode_t;

  typedef struct packed {
    sensor_mode_t         sensor_mode;
    logic [RATE_W-1:0]    rate_slow_hz;
    logic [RATE_W-1:0]    rate_medium_hz;
    logic [RATE_W-1:0]    rate_fast_hz;
    logic signed [31:0]   scale_gain;
    logic signed [31:0]   scale_offset;
    logic [WEIGHT_W-1:0]  ema_weight;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_RATE,
    ST_CHECK,
    ST_SCALE,
    ST_MUL_W,
    ST_MUL_WP,
    ST_FINISH,
    ST_OUTPUT
  } state_t;

endpackage

/* sv/rpse_cfg.sv */
// ----------------------------------------------------------------------------
// rpse_cfg
// Configuration register file; write-only, one register per index 0 to 6.
// ----------------------------------------------------------------------------
module rpse_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [rpse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpse_pkg::CFG_W-1:0]    cfg_data,
  output rpse_pkg::cfg_t                cfg
);
  import rpse_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sensor_mode    <= MODE_SLOW;
      cfg.rate_slow_hz   <= RATE_W'(10);
      cfg.rate_medium_hz <= RATE_W'(100);
      cfg.rate_fast_hz   <= RATE_W'(1000);
      cfg.scale_gain     <= 32'sd65536;
      cfg.scale_offset   <= 32'sd0;
      cfg.ema_weight     <= ONE_Q16;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SENSOR_MODE:  cfg.sensor_mode    <= sensor_mode_t'(cfg_data[1:0]);
        CFG_RATE_SLOW:    cfg.rate_slow_hz   <= cfg_data[RATE_W-1:0];
        CFG_RATE_MEDIUM:  cfg.rate_medium_hz <= cfg_data[RATE_W-1:0];
        CFG_RATE_FAST:    cfg.rate_fast_hz   <= cfg_data[RATE_W-1:0];
        CFG_SCALE_GAIN:   cfg.scale_gain     <= $signed(cfg_data);
        CFG_SCALE_OFFSET: cfg.scale_offset   <= $signed(cfg_data);
        CFG_EMA_WEIGHT:   cfg.ema_weight     <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/rpse_mul.sv */
// ----------------------------------------------------------------------------
// rpse_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module rpse_mul (
  input  logic                              clk,
  input  logic signed [rpse_pkg::MUL_A_W-1:0] op_a,
  input  logic signed [rpse_pkg::MUL_B_W-1:0] op_b,
  output logic signed [rpse_pkg::PROD_W-1:0]  prod
);
  import rpse_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(op_a * op_b);
  end

endmodule

/* sv/rpse_core.sv */
// ----------------------------------------------------------------------------
// rpse_core
// Sequencer and datapath: rate check, scaling and moving average, all through
// one shared multiplier.
// ----------------------------------------------------------------------------
module rpse_core #(
  parameter int TICKS_PER_SECOND = rpse_pkg::TICKS_PER_SECOND_DEF,
  parameter int SAMPLE_BITS      = rpse_pkg::SAMPLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  rpse_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        adc_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        raw_value,
  output logic signed [31:0] scaled_value,
  output logic signed [31:0] smoothed_value
);
  import rpse_pkg::*;

  localparam logic [15:0] RAW_MASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
  localparam logic signed [PROD_W-1:0] TICKS_P = PROD_W'(TICKS_PER_SECOND);
  localparam logic signed [PROD_W-1:0] I32_MAX = PROD_W'(64'sh7FFFFFFF);
  localparam logic signed [PROD_W-1:0] I32_MIN = -PROD_W'(64'sh80000000);
  localparam logic signed [PROD_W-1:0] HALF_Q16 = PROD_W'(32768);

  state_t state, state_next;

  logic [TICK_W-1:0]          tick_count;
  logic [15:0]                raw;
  logic signed [31:0]         scaled;
  logic signed [PROD_W-1:0]   acc;
  logic signed [31:0]         average;
  logic signed [31:0]         average_prior;

  logic signed [MUL_A_W-1:0]  op_a;
  logic signed [MUL_B_W-1:0]  op_b;
  logic signed [PROD_W-1:0]   prod;

  logic [RATE_W-1:0]          rate;
  logic [WEIGHT_W-1:0]        w_eff;
  logic [WEIGHT_W-1:0]        w_rest;
  logic                       hit;
  logic                       out_free;
  logic signed [PROD_W-1:0]   scale_sum;
  logic signed [PROD_W-1:0]   avg_sum;
  logic signed [PROD_W-1:0]   avg_floor;

  logic accept, ld_scaled, ld_acc, ld_avg, emit;

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    if (v > I32_MAX) begin
      return 32'sh7FFFFFFF;
    end else if (v < I32_MIN) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  rpse_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  always_comb begin
    unique case (cfg.sensor_mode)
      MODE_SLOW:   rate = cfg.rate_slow_hz;
      MODE_MEDIUM: rate = cfg.rate_medium_hz;
      MODE_FAST:   rate = cfg.rate_fast_hz;
      default:     rate = '0;
    endcase
  end

  // weight above one is treated as one
  assign w_eff  = cfg.ema_weight[WEIGHT_W-1] ? ONE_Q16 : cfg.ema_weight;
  assign w_rest = ONE_Q16 - w_eff;

  // tick >= T / rate  <=>  rate * (tick + 1) > T; rate zero never hits
  assign hit       = prod > TICKS_P;
  assign out_free  = !out_valid || out_ready;
  assign scale_sum = prod + PROD_W'(cfg.scale_offset);
  assign avg_sum   = acc + prod + HALF_Q16;
  assign avg_floor = avg_sum >>> 16;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_MUL_RATE;
      ST_MUL_RATE: state_next = ST_CHECK;
      ST_CHECK:    state_next = hit ? ST_SCALE : ST_IDLE;
      ST_SCALE:    state_next = ST_MUL_W;
      ST_MUL_W:    state_next = ST_MUL_WP;
      ST_MUL_WP:   state_next = ST_FINISH;
      ST_FINISH:   state_next = ST_OUTPUT;
      ST_OUTPUT:   if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // outputs and multiplier operand select
  always_comb begin
    in_ready  = 1'b0;
    accept    = 1'b0;
    ld_scaled = 1'b0;
    ld_acc    = 1'b0;
    ld_avg    = 1'b0;
    emit      = 1'b0;
    op_a      = '0;
    op_b      = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        accept   = in_valid;
      end
      ST_MUL_RATE: begin
        op_a = MUL_A_W'({1'b0, rate});
        op_b = MUL_B_W'({1'b0, tick_count} + {1'b0, {TICK_W{1'b0}}} + 21'd1);
      end
      ST_CHECK: begin
        op_a = MUL_A_W'(cfg.scale_gain);
        op_b = MUL_B_W'({1'b0, raw});
      end
      ST_SCALE: begin
        ld_scaled = 1'b1;
      end
      ST_MUL_W: begin
        op_a = MUL_A_W'(scaled);
        op_b = MUL_B_W'({1'b0, w_eff});
      end
      ST_MUL_WP: begin
        ld_acc = 1'b1;
        op_a   = MUL_A_W'(average_prior);
        op_b   = MUL_B_W'({1'b0, w_rest});
      end
      ST_FINISH: begin
        ld_avg = 1'b1;
      end
      ST_OUTPUT: begin
        emit = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      tick_count    <= '0;
      average_prior <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && tick_count != TICK_MAX) begin
        tick_count <= tick_count + TICK_W'(1);
      end else if (emit) begin
        tick_count <= '0;
      end
      if (emit) begin
        average_prior <= average;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) raw <= adc_sample & RAW_MASK;
    if (ld_scaled) scaled <= sat32(scale_sum);
    if (ld_acc) acc <= prod;
    if (ld_avg) average <= sat32(avg_floor);
    if (emit) begin
      raw_value      <= raw;
      scaled_value   <= scaled;
      smoothed_value <= average;
    end
  end

endmodule

/* sv/rate_paced_sensor_scale_ema.sv */
// ----------------------------------------------------------------------------
// rate_paced_sensor_scale_ema
// Rate-paced sensor sampler: Q16.16 linear scaling and moving average.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready, adc_sample): one beat per microsecond
// tick. The tick counter advances on each beat, saturating at its maximum;
// when it reaches TICKS_PER_SECOND / rate of the selected mode, the sample is
// scaled, folded into the moving average and one output beat is produced
// (raw_value, scaled_value, smoothed_value).
// Configuration: cfg_write/cfg_index/cfg_data, one register per index 0 to 6,
// written only while the block is idle; the block itself does not enforce this.
// Sequence: a beat that yields no result passes through MUL_RATE and CHECK
// before in_ready returns. A sampling beat passes through MUL_RATE, CHECK,
// SCALE, MUL_W, MUL_WP, FINISH and OUTPUT; out_valid rises together with
// in_ready. The single shared multiplier is used four times per sample
// (rate check, gain, two average terms).
// Receiver stall: the result waits in the output register; the next tick is
// accepted meanwhile, and a new result holds in the final step until the
// output register is free.
// Reset (rst, synchronous): registers take their defaults, tick count and
// average clear, no output beat is pending.
// ----------------------------------------------------------------------------
module rate_paced_sensor_scale_ema #(
  parameter int TICKS_PER_SECOND = rpse_pkg::TICKS_PER_SECOND_DEF,
  parameter int SAMPLE_BITS      = rpse_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [rpse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpse_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [15:0]                   adc_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   raw_value,
  output logic signed [31:0]            scaled_value,
  output logic signed [31:0]            smoothed_value
);
  import rpse_pkg::*;

  cfg_t cfg;

  rpse_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rpse_core #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .adc_sample     (adc_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .raw_value      (raw_value),
    .scaled_value   (scaled_value),
    .smoothed_value (smoothed_value)
  );

endmodule

/* sv/rpse_checker.sv */
// ----------------------------------------------------------------------------
// rpse_checker
// Port-level assertions for the sensor block, bound to the top level.
// ----------------------------------------------------------------------------
`include "rate_paced_sensor_scale_ema_defines.svh"

module rpse_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [15:0]        raw_value,
  input logic signed [31:0] scaled_value,
  input logic signed [31:0] smoothed_value
);

  // one tick at a time: busy right after a beat is taken
  `RPSE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // a result only appears once the sequencer has left idle
  `RPSE_ASSERT_NOW(a_result_from_work, $rose(out_valid), !$past(in_ready))

  `RPSE_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid)

  `RPSE_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
    $stable(raw_value) && $stable(scaled_value) && $stable(smoothed_value))

endmodule

bind rate_paced_sensor_scale_ema rpse_checker u_rpse_checker (.*);
